// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the deque
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/cdq_pkg.sv =====
// types and constants of the circular deque
// used by cdq_ctrl, cdq_datapath and circular_deque
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int DATA_W   = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_POP_REAR   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic signed [DATA_W-1:0] POP_FAIL_VALUE = -32'sd1;
    localparam logic signed [DATA_W-1:0] PUSH_VALUE_OUT = 32'sd0;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_LOAD
    } t_ctrl_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

endpackage

// ===== rtl/cdq_ctrl.sv =====
// sequencing controller of the circular deque: capture, execute, load result
// depends on cdq_pkg
`timescale 1ns / 1ps

module cdq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cdq_pkg::t_dp_stat i_stat,
    output cdq_pkg::t_dp_cmd  o_cmd
);

    cdq_pkg::t_ctrl_state r_state;
    cdq_pkg::t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdq_pkg::CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cdq_pkg::CS_IDLE: begin
                if (i_in_valid) begin
                    n_state = cdq_pkg::CS_EXEC;
                end
            end
            cdq_pkg::CS_EXEC: begin
                n_state = cdq_pkg::CS_LOAD;
            end
            cdq_pkg::CS_LOAD: begin
                // hold until the output register can take the word
                if (!i_stat.out_busy) begin
                    n_state = cdq_pkg::CS_IDLE;
                end
            end
            default: begin
                n_state = cdq_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.load    = 1'b0;
        case (r_state)
            cdq_pkg::CS_IDLE: begin
                // no word is taken while reset is held
                o_in_ready    = i_rst_n;
                o_cmd.capture = i_in_valid & i_rst_n;
            end
            cdq_pkg::CS_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            cdq_pkg::CS_LOAD: begin
                o_cmd.load = ~i_stat.out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/cdq_datapath.sv =====
// datapath of the circular deque: ring memory, indices, count and output register
// depends on cdq_pkg
`timescale 1ns / 1ps

module cdq_datapath #(
    parameter int DEPTH = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cdq_pkg::t_dp_cmd                    i_cmd,
    output cdq_pkg::t_dp_stat                   o_stat,
    input  logic [cdq_pkg::REQ_W-1:0]           i_req_type,
    input  logic signed [cdq_pkg::DATA_W-1:0]   i_push_value,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [cdq_pkg::DATA_W-1:0]   o_pop_value,
    output logic [cdq_pkg::STATUS_W-1:0]        o_status,
    output logic [$clog2(DEPTH+1)-1:0]          o_fill_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic signed [cdq_pkg::DATA_W-1:0] r_mem [DEPTH];

    logic [cdq_pkg::REQ_W-1:0]         r_req_type;
    logic signed [cdq_pkg::DATA_W-1:0] r_push_value;

    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;

    logic [cdq_pkg::STATUS_W-1:0]      r_pend_status, n_pend_status;
    logic signed [cdq_pkg::DATA_W-1:0] r_pend_value, n_pend_value;
    logic                              r_pend_use_rd, n_pend_use_rd;

    logic signed [cdq_pkg::DATA_W-1:0] r_rd_data;

    logic                              r_out_valid, n_out_valid;
    logic signed [cdq_pkg::DATA_W-1:0] r_out_value;
    logic [cdq_pkg::STATUS_W-1:0]      r_out_status;
    logic [CNT_W-1:0]                  r_out_count;

    logic             is_push, at_front, is_full, is_empty;
    logic [IDX_W-1:0] head_dec, head_inc, tail_dec, tail_inc;
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;

    always_comb begin
        is_push  = ~r_req_type[1];
        at_front = ~r_req_type[0];
        is_full  = (r_count == CNT_FULL);
        is_empty = (r_count == '0);
        head_dec = (r_head == '0) ? IDX_LAST : r_head - IDX_W'(1);
        head_inc = (r_head == IDX_LAST) ? '0 : r_head + IDX_W'(1);
        tail_dec = (r_tail == '0) ? IDX_LAST : r_tail - IDX_W'(1);
        tail_inc = (r_tail == IDX_LAST) ? '0 : r_tail + IDX_W'(1);
    end

    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_pend_status = r_pend_status;
        n_pend_value  = r_pend_value;
        n_pend_use_rd = r_pend_use_rd;
        wr_en         = 1'b0;
        wr_addr       = '0;
        rd_en         = 1'b0;
        rd_addr       = r_head;
        if (i_cmd.exec) begin
            n_pend_status = cdq_pkg::ST_DONE;
            n_pend_value  = cdq_pkg::PUSH_VALUE_OUT;
            n_pend_use_rd = 1'b0;
            if (is_push) begin
                if (is_full) begin
                    n_pend_status = cdq_pkg::ST_FULL;
                end else begin
                    wr_en = 1'b1;
                    // an empty deque restarts both ends at slot zero
                    if (is_empty) begin
                        n_head  = '0;
                        n_tail  = '0;
                        wr_addr = '0;
                    end else if (at_front) begin
                        n_head  = head_dec;
                        wr_addr = head_dec;
                    end else begin
                        n_tail  = tail_inc;
                        wr_addr = tail_inc;
                    end
                    n_count = r_count + CNT_ONE;
                end
            end else begin
                if (is_empty) begin
                    n_pend_status = cdq_pkg::ST_EMPTY;
                    n_pend_value  = cdq_pkg::POP_FAIL_VALUE;
                end else begin
                    rd_en         = 1'b1;
                    n_pend_use_rd = 1'b1;
                    rd_addr       = at_front ? r_head : r_tail;
                    // the last word leaves both indices where they are
                    if (r_count != CNT_ONE) begin
                        if (at_front) begin
                            n_head = head_inc;
                        end else begin
                            n_tail = tail_dec;
                        end
                    end
                    n_count = r_count - CNT_ONE;
                end
            end
        end
    end

    always_comb begin
        if (i_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_push_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type   <= i_req_type;
            r_push_value <= i_push_value;
        end
        r_pend_status <= n_pend_status;
        r_pend_value  <= n_pend_value;
        r_pend_use_rd <= n_pend_use_rd;
        // count already holds the value after this request
        if (i_cmd.load) begin
            r_out_value  <= r_pend_use_rd ? r_rd_data : r_pend_value;
            r_out_status <= r_pend_status;
            r_out_count  <= r_count;
        end
    end

    assign o_stat.out_busy = r_out_valid & ~i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_pop_value     = r_out_value;
    assign o_status        = r_out_status;
    assign o_fill_count    = r_out_count;

endmodule

// ===== rtl/circular_deque.sv =====
// top level of the circular deque: stream ports, controller and datapath
// depends on cdq_pkg, cdq_ctrl, cdq_datapath and assert_macros.svh
`timescale 1ns / 1ps

// Double-ended queue of up to DEPTH signed 32-bit words in a ring memory.
// Each input word is one request (push front, push rear, pop front, pop rear)
// and yields exactly one output word with the popped value, a status and the
// count after the request. A request is captured, executed against the
// memory and pointers, then loaded into the output register; the load waits
// while that register still holds a word not yet taken. The registered read
// port of the ring memory sets this sequence. The next request is taken
// while the previous result still waits in the output register. The memory
// needs no clearing after reset: only written slots are ever read.

`include "assert_macros.svh"

module circular_deque #(
    parameter int DEPTH = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // push_value
    input  logic [1:0]           s_axis_tuser,   // req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [((cdq_pkg::DATA_W + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0]
                                 m_axis_tdata,   // pop_value, fill_count
    output logic [1:0]           m_axis_tuser    // status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    cdq_pkg::t_dp_cmd  dp_cmd;
    cdq_pkg::t_dp_stat dp_stat;

    logic signed [cdq_pkg::DATA_W-1:0] pop_value;
    logic [CNT_W-1:0]                  fill_count;

    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_req_type   (s_axis_tuser),
        .i_push_value (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_pop_value  (pop_value),
        .o_status     (m_axis_tuser),
        .o_fill_count (fill_count)
    );

    always_comb begin
        m_axis_tdata                             = '0;
        m_axis_tdata[cdq_pkg::DATA_W-1:0]        = pop_value;
        m_axis_tdata[cdq_pkg::DATA_W +: CNT_W]   = fill_count;
    end

    `ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, dp_cmd.load, !dp_stat.out_busy, "result word overwritten")
    `ASSERT_NEXT(a_capture_exec, i_clk, i_rst_n, dp_cmd.capture, dp_cmd.exec, "captured request not executed")
    `ASSERT_ALWAYS(a_cmd_onehot, i_clk, i_rst_n, $onehot0({dp_cmd.capture, dp_cmd.exec, dp_cmd.load}), "commands overlap")
    `ASSERT_IMPLIES(a_full_count, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == cdq_pkg::ST_FULL), fill_count == CNT_W'(DEPTH), "full status with count below depth")
    `ASSERT_IMPLIES(a_empty_word, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == cdq_pkg::ST_EMPTY), (fill_count == '0) && (pop_value == cdq_pkg::POP_FAIL_VALUE), "bad refused pop word")

endmodule
